[sv/sds_pkg.sv]
package sds_pkg;

    localparam int RADIUS_BITS    = 9;
    localparam int LEVEL_BITS     = 8;
    localparam int FULL_LEVEL     = 255;
    localparam int ADDR_BITS      = 4;
    localparam int DATA_BITS      = 32;

    localparam int COORD_BITS_DEF = 10;
    localparam int LIGHT_BITS_DEF = 12;

    localparam int RESET_RADIUS   = 250;
    localparam int RESET_LIGHT_X  = -350;
    localparam int RESET_LIGHT_Y  = -350;
    localparam int RESET_LIGHT_Z  = 450;

    localparam logic [1:0] REG_RADIUS  = 2'd0;
    localparam logic [1:0] REG_LIGHT_X = 2'd1;
    localparam logic [1:0] REG_LIGHT_Y = 2'd2;
    localparam logic [1:0] REG_LIGHT_Z = 2'd3;

endpackage

[sv/sds_root_step.sv]
module sds_root_step #(
    parameter int RW  = sds_pkg::RADIUS_BITS,
    parameter int BIT = 0
) (
    input  logic                clk,
    input  logic                en,
    input  logic [2*RW-1:0]     rad,
    input  logic [RW-1:0]       root_in,
    output logic [RW-1:0]       root_out_reg
);

    logic [RW-1:0]   trial;
    logic [2*RW-1:0] trial_sq;

    // try this root bit, keep it if its square still fits
    assign trial    = root_in | (RW'(1) << BIT);
    assign trial_sq = (2*RW)'(trial) * (2*RW)'(trial);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            root_out_reg <= (trial_sq <= rad) ? trial : root_in;
        end
    end

endmodule

[sv/sds_level_step.sv]
module sds_level_step #(
    parameter int AW  = 44,
    parameter int NSW = 64,
    parameter int BIT = 0
) (
    input  logic                               clk,
    input  logic                               en,
    input  logic [AW-1:0]                      a,
    input  logic [NSW-1:0]                     nsq,
    input  logic [sds_pkg::LEVEL_BITS-1:0]     c_in,
    input  logic [2*sds_pkg::LEVEL_BITS-1:0]   csq_in,
    output logic [sds_pkg::LEVEL_BITS-1:0]     c_out_reg,
    output logic [2*sds_pkg::LEVEL_BITS-1:0]   csq_out_reg
);

    localparam int CL   = sds_pkg::LEVEL_BITS;
    localparam int SQW  = 2 * CL;
    localparam int PW   = SQW + AW;
    localparam int CMPW = (PW > NSW) ? PW : NSW;

    logic [CL-1:0]  trial;
    logic [SQW:0]   trial_sq_w;
    logic [SQW-1:0] trial_sq;
    logic [PW-1:0]  prod;

    // (c + 2^b)^2 = c^2 + c*2^(b+1) + 2^(2b), c has no bits at or below b
    assign trial      = c_in | (CL'(1) << BIT);
    assign trial_sq_w = (SQW+1)'(csq_in) + ((SQW+1)'(c_in) << (BIT + 1))
                      + ((SQW+1)'(1) << (2 * BIT));
    assign trial_sq   = trial_sq_w[SQW-1:0];
    assign prod       = PW'(trial_sq) * PW'(a);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (CMPW'(prod) <= CMPW'(nsq))
            begin
                c_out_reg   <= trial;
                csq_out_reg <= trial_sq;
            end
            else
            begin
                c_out_reg   <= c_in;
                csq_out_reg <= csq_in;
            end
        end
    end

endmodule

[sv/sphere_diffuse_pixel_shader.sv]
// lambert diffuse shading of a sphere, one pixel per transfer
// input channel: pixel_x, pixel_y relative to the sphere centre, with
// in_valid / in_stall; output channel: grey_level, on_sphere with
// out_valid / out_stall. one result for every input transfer, in order.
// configuration through the apb port: radius at 0x0, light x/y/z at
// 0x4, 0x8, 0xc; write only while no pixel is in flight.
// throughput: one pixel per cycle while out_stall is low; the pipeline
// has no feedback loop. stages: 3 front stages, 9 square root stages,
// 5 dot product / norm stages, 8 level search stages; 25 registered
// stages in all.
// out_stall holds the last stage; earlier stages keep filling bubbles
// and in_stall rises only once the first stage is full and cannot move.
// reset clears all valid bits and loads radius 250, light (-350,-350,450).
module sphere_diffuse_pixel_shader #(
    parameter int COORD_BITS = sds_pkg::COORD_BITS_DEF,
    parameter int LIGHT_BITS = sds_pkg::LIGHT_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [COORD_BITS-1:0]       pixel_x,
    input  logic signed [COORD_BITS-1:0]       pixel_y,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [sds_pkg::LEVEL_BITS-1:0]     grey_level,
    output logic                               on_sphere,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [sds_pkg::ADDR_BITS-1:0]      paddr,
    input  logic [sds_pkg::DATA_BITS-1:0]      pwdata,
    output logic [sds_pkg::DATA_BITS-1:0]      prdata,
    output logic                               pready
);

    localparam int CW    = COORD_BITS;
    localparam int LW    = LIGHT_BITS;
    localparam int RB    = sds_pkg::RADIUS_BITS;
    localparam int CL    = sds_pkg::LEVEL_BITS;
    localparam int DBW   = sds_pkg::DATA_BITS;
    localparam int R2W   = 2 * RB;
    localparam int RHOW  = 2 * CW;
    localparam int RCW   = (RHOW > R2W) ? RHOW : R2W;
    localparam int PW    = (CW > RB + 1) ? CW : RB + 1;
    localparam int DW    = ((LW > PW) ? LW : PW) + 1;
    localparam int MW    = PW + DW;
    localparam int DOTW  = MW + 1;
    localparam int DDW   = 2 * DW;
    localparam int AW    = R2W + DDW;
    localparam int NW    = DOTW + 7;
    localparam int NSW   = 2 * NW;

    localparam int S_RAD = 2;
    localparam int S_D   = S_RAD + RB + 1;
    localparam int S_MUL = S_D + 1;
    localparam int S_SUM = S_D + 2;
    localparam int S_A   = S_D + 3;
    localparam int S_NSQ = S_D + 4;
    localparam int NST   = S_NSQ + CL + 1;

    // configuration
    logic [RB-1:0] radius_reg;
    logic [LW-1:0] light_x_reg;
    logic [LW-1:0] light_y_reg;
    logic [LW-1:0] light_z_reg;
    logic          cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg  <= RB'(sds_pkg::RESET_RADIUS);
            light_x_reg <= LW'(sds_pkg::RESET_LIGHT_X);
            light_y_reg <= LW'(sds_pkg::RESET_LIGHT_Y);
            light_z_reg <= LW'(sds_pkg::RESET_LIGHT_Z);
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                sds_pkg::REG_RADIUS:  radius_reg  <= pwdata[RB-1:0];
                sds_pkg::REG_LIGHT_X: light_x_reg <= pwdata[LW-1:0];
                sds_pkg::REG_LIGHT_Y: light_y_reg <= pwdata[LW-1:0];
                sds_pkg::REG_LIGHT_Z: light_z_reg <= pwdata[LW-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            sds_pkg::REG_RADIUS:  prdata = DBW'(radius_reg);
            sds_pkg::REG_LIGHT_X: prdata = DBW'(light_x_reg);
            sds_pkg::REG_LIGHT_Y: prdata = DBW'(light_y_reg);
            sds_pkg::REG_LIGHT_Z: prdata = DBW'(light_z_reg);
            default:              prdata = '0;
        endcase
    end

    // pipeline control: a stage moves when it is empty or the next one moves
    logic v_reg [NST];
    logic en    [NST];

    always_comb
    begin
        en[NST-1] = !v_reg[NST-1] || !out_stall;
        for (int k = NST - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign in_stall = !en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NST; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < NST; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // input stage and x^2 + y^2
    logic signed [CW-1:0] px_reg, py_reg, x1_reg, y1_reg;
    logic [RHOW-1:0]      rho1_reg;
    logic [R2W-1:0]       r2;

    assign r2 = R2W'(radius_reg) * R2W'(radius_reg);

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            px_reg <= pixel_x;
            py_reg <= pixel_y;
        end
        if (en[1])
        begin
            x1_reg   <= px_reg;
            y1_reg   <= py_reg;
            rho1_reg <= RHOW'(px_reg) * RHOW'(px_reg) + RHOW'(py_reg) * RHOW'(py_reg);
        end
    end

    // disc test and square root chain
    logic signed [CW-1:0] xq_reg   [RB+1];
    logic signed [CW-1:0] yq_reg   [RB+1];
    logic [R2W-1:0]       rhoq_reg [RB+1];
    logic [R2W-1:0]       radq_reg [RB+1];
    logic                 inq_reg  [RB+1];
    logic [RB-1:0]        root     [RB+1];
    logic                 in_disc;

    assign in_disc = RCW'(rho1_reg) <= RCW'(r2);
    assign root[0] = '0;

    always_ff @(posedge clk)
    begin
        if (en[S_RAD])
        begin
            xq_reg[0]   <= x1_reg;
            yq_reg[0]   <= y1_reg;
            rhoq_reg[0] <= rho1_reg[R2W-1:0];
            radq_reg[0] <= in_disc ? r2 - rho1_reg[R2W-1:0] : '0;
            inq_reg[0]  <= in_disc;
        end
    end

    for (genvar j = 1; j <= RB; j++)
    begin : g_root
        always_ff @(posedge clk)
        begin
            if (en[S_RAD+j])
            begin
                xq_reg[j]   <= xq_reg[j-1];
                yq_reg[j]   <= yq_reg[j-1];
                rhoq_reg[j] <= rhoq_reg[j-1];
                radq_reg[j] <= radq_reg[j-1];
                inq_reg[j]  <= inq_reg[j-1];
            end
        end

        sds_root_step #(
            .RW  (RB),
            .BIT (RB - j)
        ) u_root (
            .clk          (clk),
            .en           (en[S_RAD+j]),
            .rad          (radq_reg[j-1]),
            .root_in      (root[j-1]),
            .root_out_reg (root[j])
        );
    end

    // normal, light direction, products, sums
    logic signed [PW-1:0]   pxd_reg, pyd_reg, pzd_reg;
    logic signed [DW-1:0]   dx_reg, dy_reg, dz_reg;
    logic [R2W-1:0]         rhod_reg, rhom_reg;
    logic                   ind_reg, inm_reg, ins_reg, ina_reg;
    logic signed [MW-1:0]   mx_reg, my_reg, mz_reg;
    logic [DDW-1:0]         sx_reg, sy_reg, sz_reg;
    logic [R2W-1:0]         zz_reg;
    logic signed [DOTW-1:0] dot_reg;
    logic [DDW-1:0]         dd_reg;
    logic [R2W-1:0]         pp_reg;
    logic [AW-1:0]          a_reg;
    logic [NW-1:0]          n_reg;
    logic                   lita_reg;
    logic signed [PW-1:0]   pz_w, pxn_w, pyn_w;
    logic                   dot_pos;

    assign pxn_w   = PW'(xq_reg[RB]);
    assign pyn_w   = PW'(yq_reg[RB]);
    assign pz_w    = signed'(PW'(root[RB]));
    assign dot_pos = !dot_reg[DOTW-1] && (dot_reg != '0);

    always_ff @(posedge clk)
    begin
        if (en[S_D])
        begin
            pxd_reg  <= pxn_w;
            pyd_reg  <= pyn_w;
            pzd_reg  <= pz_w;
            dx_reg   <= DW'(signed'(light_x_reg)) - DW'(pxn_w);
            dy_reg   <= DW'(signed'(light_y_reg)) - DW'(pyn_w);
            dz_reg   <= DW'(signed'(light_z_reg)) - DW'(pz_w);
            rhod_reg <= rhoq_reg[RB];
            ind_reg  <= inq_reg[RB];
        end
        if (en[S_MUL])
        begin
            mx_reg   <= MW'(pxd_reg) * MW'(dx_reg);
            my_reg   <= MW'(pyd_reg) * MW'(dy_reg);
            mz_reg   <= MW'(pzd_reg) * MW'(dz_reg);
            sx_reg   <= DDW'(DDW'(dx_reg) * DDW'(dx_reg));
            sy_reg   <= DDW'(DDW'(dy_reg) * DDW'(dy_reg));
            sz_reg   <= DDW'(DDW'(dz_reg) * DDW'(dz_reg));
            zz_reg   <= R2W'(pzd_reg[RB-1:0]) * R2W'(pzd_reg[RB-1:0]);
            rhom_reg <= rhod_reg;
            inm_reg  <= ind_reg;
        end
        if (en[S_SUM])
        begin
            dot_reg <= DOTW'(mx_reg) + DOTW'(my_reg) + DOTW'(mz_reg);
            dd_reg  <= sx_reg + sy_reg + sz_reg;
            pp_reg  <= rhom_reg + zz_reg;
            ins_reg <= inm_reg;
        end
        if (en[S_A])
        begin
            a_reg    <= AW'(pp_reg) * AW'(dd_reg);
            n_reg    <= NW'(unsigned'(dot_reg)) * NW'(sds_pkg::FULL_LEVEL);
            lita_reg <= ins_reg && dot_pos;
            ina_reg  <= ins_reg;
        end
    end

    // (255 * p.d)^2 and the level search
    logic [AW-1:0]    al_reg   [CL+1];
    logic [NSW-1:0]   nsq_reg  [CL+1];
    logic             lit_reg  [CL+1];
    logic             inl_reg  [CL+1];
    logic [CL-1:0]    c        [CL+1];
    logic [2*CL-1:0]  csq      [CL+1];

    assign c[0]   = '0;
    assign csq[0] = '0;

    always_ff @(posedge clk)
    begin
        if (en[S_NSQ])
        begin
            al_reg[0]  <= a_reg;
            nsq_reg[0] <= NSW'(n_reg) * NSW'(n_reg);
            lit_reg[0] <= lita_reg;
            inl_reg[0] <= ina_reg;
        end
    end

    for (genvar j = 1; j <= CL; j++)
    begin : g_level
        always_ff @(posedge clk)
        begin
            if (en[S_NSQ+j])
            begin
                al_reg[j]  <= al_reg[j-1];
                nsq_reg[j] <= nsq_reg[j-1];
                lit_reg[j] <= lit_reg[j-1];
                inl_reg[j] <= inl_reg[j-1];
            end
        end

        sds_level_step #(
            .AW  (AW),
            .NSW (NSW),
            .BIT (CL - j)
        ) u_level (
            .clk         (clk),
            .en          (en[S_NSQ+j]),
            .a           (al_reg[j-1]),
            .nsq         (nsq_reg[j-1]),
            .c_in        (c[j-1]),
            .csq_in      (csq[j-1]),
            .c_out_reg   (c[j]),
            .csq_out_reg (csq[j])
        );
    end

    assign out_valid  = v_reg[NST-1];
    assign grey_level = lit_reg[CL] ? c[CL] : '0;
    assign on_sphere  = inl_reg[CL];

    a_black_off_disc: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !on_sphere |-> grey_level == '0)
        else $error("grey level set off the disc");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> v_reg[0])
        else $error("input stalled with empty first stage");

    a_transfer_enters: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> v_reg[0])
        else $error("accepted transfer lost at first stage");

    a_held_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(grey_level))
        else $error("stalled result dropped or changed");

endmodule
